// ===== rtl/core/hva_pkg.sv =====
// Shared types and constants for the homogeneous vector ALU.
// No dependencies; compiled first.
package hva_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int TOL_BITS      = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);
  localparam int MODE_BITS     = 3;
  localparam int ERR_BITS      = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_NEG  = 3'd2,
    MODE_MAG  = 3'd3,
    MODE_NORM = 3'd4,
    MODE_EQ   = 3'd5
  } mode_t;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_NONE         = 2'd0,
    ERR_PT_PLUS_PT   = 2'd1,
    ERR_VEC_MINUS_PT = 2'd2,
    ERR_ZERO_NORM    = 2'd3
  } err_t;

  // sideband that rides the pipeline next to the data
  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 aw;
    logic                 rw;
    err_t                 err;
    logic                 same;
  } ctl_t;

  localparam int CTL_BITS = $bits(ctl_t);

endpackage

// ===== rtl/core/hva_if.sv =====
// Request and response channel interfaces for the vector ALU.
// Depends on hva_pkg.
interface hva_req_if #(parameter int W = hva_pkg::WORD_BITS);
  import hva_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MODE_BITS-1:0] mode;
  logic signed [W-1:0]  a_x, a_y, a_z;
  logic                 a_w;
  logic signed [W-1:0]  b_x, b_y, b_z;
  logic                 b_w;

  modport source(output valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                 input ready);
  modport sink(input valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
               output ready);
endinterface

interface hva_rsp_if #(parameter int W = hva_pkg::WORD_BITS);
  import hva_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [W-1:0]  r_x, r_y, r_z;
  logic                 r_w;
  logic [W:0]           length;
  logic                 same;
  logic [ERR_BITS-1:0]  error_code;

  modport source(output valid, r_x, r_y, r_z, r_w, length, same, error_code,
                 input ready);
  modport sink(input valid, r_x, r_y, r_z, r_w, length, same, error_code,
               output ready);
endinterface

// ===== rtl/core/homogeneous_vector_alu_core.sv =====
// Top level of the homogeneous 3D vector ALU: front, root, divider, output queue.
// Depends on hva_pkg, hva_if, hva_front, hva_sqrt, hva_div.
//
// Usage: req carries one operation word (mode, tuples a and b); rsp returns one
// result word per request, in order. Both are valid/ready channels; a word moves
// on a clock edge with valid and ready high. cfg_we/cfg_data write the equality
// tolerance (raw fixed-point units), to be done while the block is idle.
// Pipeline: 3 front stages, (WORD_BITS+1) square-root stages, (FRACTION_BITS+1)
// divider stages and 1 result stage into the output queue; every mode takes the
// full path. Throughput: one word per cycle while the output queue is not full.
// The square-root and divider pipelines, one bit per stage, set the latency;
// nothing in the path iterates.
// Reset: rst clears all valid bits and the queue and sets the tolerance to 1;
// the block takes words in the first cycle after reset.
// Stall: a two-word output queue decouples rsp.ready from req.ready. The whole
// pipeline freezes when the queue is full, so no word is lost or repeated, and
// req.ready only depends on registered queue state.
module homogeneous_vector_alu_core #(
  parameter int WORD_BITS     = hva_pkg::WORD_BITS,
  parameter int FRACTION_BITS = hva_pkg::FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  hva_req_if.sink                      req,
  hva_rsp_if.source                    rsp,
  input  logic                         cfg_we,
  input  logic [hva_pkg::TOL_BITS-1:0] cfg_data
);
  import hva_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int RB = W + 1;
  localparam int SIDE_S = CTL_BITS + 6*W + 3;
  localparam int SIDE_D = CTL_BITS + 3*W + 3;

  logic [TOL_BITS-1:0] tol;
  always_ff @(posedge clk) begin
    if (rst) tol <= TOL_RESET;
    else if (cfg_we) tol <= cfg_data;
  end

  logic [1:0] count;
  logic       en;
  assign en        = (count != 2'd2);
  assign req.ready = en;

  // front
  logic              f_v;
  ctl_t              f_ctl;
  logic [2:0][W-1:0] f_rs, f_ua;
  logic [2:0]        f_neg;
  logic [2*W+1:0]    f_sum;

  hva_front #(.W(W)) u_front (
    .clk, .rst, .en,
    .in_valid (req.valid),
    .mode     (req.mode),
    .a        ({req.a_z, req.a_y, req.a_x}),
    .aw       (req.a_w),
    .b        ({req.b_z, req.b_y, req.b_x}),
    .bw       (req.b_w),
    .tol,
    .out_valid(f_v),
    .out_ctl  (f_ctl),
    .out_rs   (f_rs),
    .out_ua   (f_ua),
    .out_neg  (f_neg),
    .out_sum  (f_sum)
  );

  // root
  logic              s_v;
  logic [RB-1:0]     s_len;
  logic [SIDE_S-1:0] s_side;
  ctl_t              s_ctl;
  logic [2:0][W-1:0] s_rs, s_ua;
  logic [2:0]        s_neg;

  hva_sqrt #(.RB(RB), .SIDE(SIDE_S)) u_sqrt (
    .clk, .rst, .en,
    .in_valid (f_v),
    .rad      (f_sum),
    .side_in  ({f_ctl, f_rs, f_ua, f_neg}),
    .out_valid(s_v),
    .root     (s_len),
    .side_out (s_side)
  );
  assign {s_ctl, s_rs, s_ua, s_neg} = s_side;

  // divider
  logic              d_v;
  logic [W:0]        d_len;
  logic [2:0][F:0]   d_q;
  logic [SIDE_D-1:0] d_side;
  ctl_t              d_ctl;
  logic [2:0][W-1:0] d_rs;
  logic [2:0]        d_neg;

  hva_div #(.W(W), .F(F), .SIDE(SIDE_D)) u_div (
    .clk, .rst, .en,
    .in_valid (s_v),
    .len      (s_len),
    .ua       (s_ua),
    .side_in  ({s_ctl, s_rs, s_neg}),
    .out_valid(d_v),
    .len_out  (d_len),
    .quo      (d_q),
    .side_out (d_side)
  );
  assign {d_ctl, d_rs, d_neg} = d_side;

  // result assembly
  logic [2:0][W-1:0]   res_r;
  logic                res_w;
  logic [W:0]          res_len;
  logic                res_same;
  logic [ERR_BITS-1:0] res_err;

  always_comb begin
    res_r    = '0;
    res_w    = 1'b0;
    res_len  = '0;
    res_same = 1'b0;
    res_err  = ERR_NONE;
    unique case (d_ctl.mode)
      MODE_ADD, MODE_SUB, MODE_NEG: begin
        res_r   = d_rs;
        res_w   = d_ctl.rw;
        res_err = d_ctl.err;
      end
      MODE_MAG: res_len = d_len;
      MODE_NORM: begin
        res_w = d_ctl.aw;
        if (d_len == '0) res_err = ERR_ZERO_NORM;
        else begin
          for (int i = 0; i < 3; i++)
            res_r[i] = d_neg[i] ? W'(-W'(d_q[i])) : W'(d_q[i]);
        end
      end
      MODE_EQ: res_same = d_ctl.same;
      default: ;
    endcase
  end

  // output queue, two words
  typedef struct packed {
    logic [2:0][W-1:0]   r;
    logic                w;
    logic [W:0]          len;
    logic                same;
    logic [ERR_BITS-1:0] err;
  } res_t;

  res_t q_mem [2];
  logic wr_ptr, rd_ptr;
  logic push, pop;

  assign push = en && d_v;
  assign pop  = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= '{r: res_r, w: res_w, len: res_len,
                                 same: res_same, err: res_err};
  end

  res_t head;
  assign head           = q_mem[rd_ptr];
  assign rsp.valid      = (count != 2'd0);
  assign rsp.r_x        = head.r[0];
  assign rsp.r_y        = head.r[1];
  assign rsp.r_z        = head.r[2];
  assign rsp.r_w        = head.w;
  assign rsp.length     = head.len;
  assign rsp.same       = head.same;
  assign rsp.error_code = head.err;

endmodule

// ===== rtl/core/hva_front.sv =====
// Front stages: add/sub/negate/compare, component magnitudes, squares, sum.
// Depends on hva_pkg.
module hva_front #(
  parameter int W = hva_pkg::WORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [hva_pkg::MODE_BITS-1:0] mode,
  input  logic [2:0][W-1:0]            a,
  input  logic                         aw,
  input  logic [2:0][W-1:0]            b,
  input  logic                         bw,
  input  logic [hva_pkg::TOL_BITS-1:0] tol,
  output logic                         out_valid,
  output hva_pkg::ctl_t                out_ctl,
  output logic [2:0][W-1:0]            out_rs,
  output logic [2:0][W-1:0]            out_ua,
  output logic [2:0]                   out_neg,
  output logic [2*W+1:0]               out_sum
);
  import hva_pkg::*;

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [2:0][W-1:0] add_r, sub_r, neg_r, ua_c;
  logic [2:0]        match;
  ctl_t              ctl_c;
  logic [2:0][W-1:0] rs_c;

  always_comb begin
    logic [W:0] s, d, ad;
    for (int i = 0; i < 3; i++) begin
      s = {a[i][W-1], a[i]} + {b[i][W-1], b[i]};
      add_r[i] = (s[W] != s[W-1]) ? (s[W] ? MINV : MAXV) : s[W-1:0];
      d = {a[i][W-1], a[i]} - {b[i][W-1], b[i]};
      sub_r[i] = (d[W] != d[W-1]) ? (d[W] ? MINV : MAXV) : d[W-1:0];
      neg_r[i] = (a[i] == MINV) ? MAXV : W'(-a[i]);
      ad = d[W] ? (W+1)'(-d) : d;
      match[i] = ad < (W+1)'(tol);
      ua_c[i] = a[i][W-1] ? W'(-a[i]) : a[i];
    end
  end

  always_comb begin
    ctl_c      = '0;
    ctl_c.mode = mode;
    ctl_c.aw   = aw;
    ctl_c.err  = ERR_NONE;
    rs_c       = '0;
    unique case (mode)
      MODE_ADD: begin
        if (aw && bw) ctl_c.err = ERR_PT_PLUS_PT;
        else begin
          rs_c     = add_r;
          ctl_c.rw = aw | bw;
        end
      end
      MODE_SUB: begin
        if (!aw && bw) ctl_c.err = ERR_VEC_MINUS_PT;
        else begin
          rs_c     = sub_r;
          ctl_c.rw = aw & ~bw;
        end
      end
      MODE_NEG: begin
        rs_c     = neg_r;
        ctl_c.rw = aw;
      end
      MODE_EQ: ctl_c.same = (aw == bw) && (&match);
      default: ;
    endcase
  end

  logic              v1, v2;
  ctl_t              ctl1, ctl2;
  logic [2:0][W-1:0] rs1, rs2, ua1, ua2;
  logic [2:0]        neg1, neg2;
  logic [2:0][2*W-1:0] sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1 <= ctl_c;
      rs1  <= rs_c;
      ua1  <= ua_c;
      neg1 <= {a[2][W-1], a[1][W-1], a[0][W-1]};
      ctl2 <= ctl1;
      rs2  <= rs1;
      ua2  <= ua1;
      neg2 <= neg1;
      for (int i = 0; i < 3; i++) sq2[i] <= ua1[i] * ua1[i];
      out_ctl <= ctl2;
      out_rs  <= rs2;
      out_ua  <= ua2;
      out_neg <= neg2;
      out_sum <= (2*W+2)'(sq2[0]) + (2*W+2)'(sq2[1]) + (2*W+2)'(sq2[2]);
    end
  end

endmodule

// ===== rtl/core/hva_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband delay.
// Depends on hva_pkg (style only).
module hva_sqrt #(
  parameter int RB   = hva_pkg::WORD_BITS + 1,
  parameter int SIDE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RB-1:0]   rad,
  input  logic [SIDE-1:0]   side_in,
  output logic              out_valid,
  output logic [RB-1:0]     root,
  output logic [SIDE-1:0]   side_out
);
  import hva_pkg::*;

  logic              v_q    [RB+1];
  logic [2*RB-1:0]   rad_q  [RB+1];
  logic [RB:0]       rem_q  [RB+1];
  logic [RB-1:0]     root_q [RB+1];
  logic [SIDE-1:0]   side_q [RB+1];

  assign v_q[0]    = in_valid;
  assign rad_q[0]  = rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RB+2:0] rem_sh, trial;
    logic          fits;
    always_comb begin
      rem_sh = {rem_q[k], rad_q[k][2*RB-1 -: 2]};
      trial  = {1'b0, root_q[k], 2'b01};
      fits   = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) v_q[k+1] <= 1'b0;
      else if (en) v_q[k+1] <= v_q[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k+1]  <= {rad_q[k][2*RB-3:0], 2'b00};
        rem_q[k+1]  <= fits ? (RB+1)'(rem_sh - trial) : rem_sh[RB:0];
        root_q[k+1] <= {root_q[k][RB-2:0], fits};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid = v_q[RB];
  assign root      = root_q[RB];
  assign side_out  = side_q[RB];

endmodule

// ===== rtl/core/hva_div.sv =====
// Three-lane restoring divider for normalize: q = floor(u * 2^F / len).
// Depends on hva_pkg (style only).
module hva_div #(
  parameter int W    = hva_pkg::WORD_BITS,
  parameter int F    = hva_pkg::FRACTION_BITS,
  parameter int SIDE = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [W:0]           len,
  input  logic [2:0][W-1:0]    ua,
  input  logic [SIDE-1:0]      side_in,
  output logic                 out_valid,
  output logic [W:0]           len_out,
  output logic [2:0][F:0]      quo,
  output logic [SIDE-1:0]      side_out
);
  import hva_pkg::*;

  localparam int ST = F + 1;

  logic                v_q    [ST+1];
  logic [W:0]          len_q  [ST+1];
  logic [2:0][W-1:0]   ua_q   [ST+1];
  logic [2:0][W:0]     rem_q  [ST+1];
  logic [2:0][F:0]     q_q    [ST+1];
  logic [SIDE-1:0]     side_q [ST+1];

  assign v_q[0]    = in_valid;
  assign len_q[0]  = len;
  assign ua_q[0]   = ua;
  assign rem_q[0]  = '0;
  assign q_q[0]    = '0;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < ST; k++) begin : g_stage
    logic [2:0][W+1:0] t;
    logic [2:0]        ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        // first step divides the magnitude itself, later steps the doubled rest
        t[i]  = (k == 0) ? (W+2)'(ua_q[k][i]) : {rem_q[k][i], 1'b0};
        ge[i] = t[i] >= (W+2)'(len_q[k]);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v_q[k+1] <= 1'b0;
      else if (en) v_q[k+1] <= v_q[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        len_q[k+1]  <= len_q[k];
        ua_q[k+1]   <= ua_q[k];
        side_q[k+1] <= side_q[k];
        for (int i = 0; i < 3; i++) begin
          rem_q[k+1][i] <= ge[i] ? (W+1)'(t[i] - (W+2)'(len_q[k])) : t[i][W:0];
          q_q[k+1][i]   <= {q_q[k][i][F-1:0], ge[i]};
        end
      end
    end
  end

  assign out_valid = v_q[ST];
  assign len_out   = len_q[ST];
  assign quo       = q_q[ST];
  assign side_out  = side_q[ST];

endmodule

// ===== rtl/core/hva_checker.sv =====
// Port-level checks for the vector ALU, bound onto the top level.
// Depends on hva_pkg and homogeneous_vector_alu_core.
module hva_checker #(
  parameter int W = hva_pkg::WORD_BITS
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [W-1:0]                 r_x,
  input logic [W-1:0]                 r_y,
  input logic [W-1:0]                 r_z,
  input logic [W:0]                   length,
  input logic                         same,
  input logic [hva_pkg::ERR_BITS-1:0] error_code
);
  import hva_pkg::*;

  // a held result word stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("rsp valid right after reset");

  // the block only refuses input when finished words are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("req stalled with nothing to deliver");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error_code != ERR_NONE |->
      r_x == '0 && r_y == '0 && r_z == '0 && length == '0 && !same)
    else $error("error word carries data");

  a_same_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && same |->
      error_code == ERR_NONE && length == '0 && r_x == '0 && r_y == '0 && r_z == '0)
    else $error("equal word carries other data");

endmodule

bind homogeneous_vector_alu_core hva_checker #(.W(WORD_BITS)) u_hva_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .r_x        (rsp.r_x),
  .r_y        (rsp.r_y),
  .r_z        (rsp.r_z),
  .length     (rsp.length),
  .same       (rsp.same),
  .error_code (rsp.error_code)
);
